@@ design/pad_pkg.sv @@
package pad_pkg;

  localparam int unsigned ObjW = 32;
  localparam int unsigned TolW = 16;
  localparam int unsigned CntW = 7;

  typedef enum logic [1:0] {
    KIND_LOAD     = 2'd0,
    KIND_CLASSIFY = 2'd1,
    KIND_INSERT   = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_DOMINATED = 2'd0,
    VERDICT_DOMINATES = 2'd1,
    VERDICT_NEUTRAL   = 2'd2
  } verdict_t;

  localparam logic [0:0] REG_TOL_FIRST = 1'b0;
  localparam logic [0:0] REG_TOL_MARGIN = 1'b1;

  typedef struct packed {
    kind_t            kind;
    logic [ObjW-1:0]  obj_first;
    logic [ObjW-1:0]  obj_second;
  } cmd_t;

  typedef struct packed {
    verdict_t         verdict;
    logic [CntW-1:0]  removed_count;
    logic             stored;
    logic             overflow;
    logic [CntW-1:0]  entry_count;
  } res_t;

  // True when point a dominates point b under the given tolerances.
  function automatic logic dominates(
    input logic [ObjW-1:0] a1, input logic [ObjW-1:0] a2,
    input logic [ObjW-1:0] b1, input logic [ObjW-1:0] b2,
    input logic [TolW-1:0] tol_f, input logic [TolW-1:0] tol_m
  );
    logic signed [ObjW:0] d_ab1;
    logic signed [ObjW:0] d_ba1;
    logic signed [ObjW:0] d_ab2;
    logic signed [ObjW:0] d_ba2;
    logic signed [ObjW:0] tf;
    logic signed [ObjW:0] tm;
    logic better;
    d_ab1 = {a1[ObjW-1], a1} - {b1[ObjW-1], b1};
    d_ba1 = {b1[ObjW-1], b1} - {a1[ObjW-1], a1};
    d_ab2 = {a2[ObjW-1], a2} - {b2[ObjW-1], b2};
    d_ba2 = {b2[ObjW-1], b2} - {a2[ObjW-1], a2};
    tf = $signed({{(ObjW+1-TolW){1'b0}}, tol_f});
    tm = $signed({{(ObjW+1-TolW){1'b0}}, tol_m});
    better = (d_ba1 > tm) || (d_ba2 > tm);
    return (d_ab1 <= tf) && (d_ab2 <= tm) && better;
  endfunction

endpackage

@@ design/pad_front.sv @@
module pad_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pad_pkg::cmd_t   in_cmd,
  output logic            q_valid,
  input  logic            q_ready,
  output pad_pkg::cmd_t   q_cmd
);
  import pad_pkg::*;

  // Two-entry queue between the accept side and the archive engine.
  cmd_t       buf_cmd [2];
  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = buf_cmd[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_cmd[wr_ptr] <= in_cmd;
    end
  end

endmodule

@@ design/pad_back.sv @@
module pad_back #(
  parameter int unsigned ARCHIVE_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [pad_pkg::TolW-1:0] tol_first,
  input  logic [pad_pkg::TolW-1:0] tol_margin,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  pad_pkg::cmd_t           q_cmd,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pad_pkg::res_t           out_res,
  output logic                    busy
);
  import pad_pkg::*;

  localparam int unsigned AW = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(ARCHIVE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN1, ST_SCAN2, ST_APPEND, ST_DONE
  } state_t;

  state_t          state;
  cmd_t            cur;
  logic [ObjW-1:0] mem_first  [ARCHIVE_DEPTH];
  logic [ObjW-1:0] mem_second [ARCHIVE_DEPTH];
  logic [ObjW-1:0] rd_first;
  logic [ObjW-1:0] rd_second;
  logic [NW-1:0]   count;
  logic [NW-1:0]   rd_idx;
  logic [NW-1:0]   wr_idx;
  logic [NW-1:0]   removed;
  logic            rd_live;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [ObjW-1:0] wr_first;
  logic [ObjW-1:0] wr_second;
  logic            dom_by;
  logic            dom_over;

  assign q_ready = (state == ST_IDLE);
  assign busy    = (state != ST_IDLE);
  assign dom_by  = dominates(rd_first, rd_second, cur.obj_first, cur.obj_second,
                             tol_first, tol_margin);
  assign dom_over = dominates(cur.obj_first, cur.obj_second, rd_first, rd_second,
                              tol_first, tol_margin);

  always_ff @(posedge clk) begin
    rd_first  <= mem_first[rd_idx[AW-1:0]];
    rd_second <= mem_second[rd_idx[AW-1:0]];
    if (wr_en) begin
      mem_first[wr_addr]  <= wr_first;
      mem_second[wr_addr] <= wr_second;
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = wr_idx[AW-1:0];
    wr_first  = rd_first;
    wr_second = rd_second;
    if (state == ST_SCAN2 && rd_live && cur.kind == KIND_INSERT && !dom_over) begin
      wr_en = 1'b1;
    end else if (state == ST_APPEND && count < NW'(ARCHIVE_DEPTH)) begin
      wr_en     = 1'b1;
      wr_addr   = count[AW-1:0];
      wr_first  = cur.obj_first;
      wr_second = cur.obj_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rd_idx    <= '0;
      rd_live   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur     <= q_cmd;
            rd_idx  <= '0;
            rd_live <= 1'b0;
            wr_idx  <= '0;
            removed <= '0;
            out_res.verdict       <= VERDICT_NEUTRAL;
            out_res.removed_count <= '0;
            out_res.stored        <= 1'b0;
            out_res.overflow      <= 1'b0;
            case (q_cmd.kind)
              KIND_LOAD:     state <= ST_APPEND;
              KIND_CLASSIFY: state <= ST_SCAN1;
              KIND_INSERT:   state <= ST_SCAN1;
              default:       state <= ST_DONE;
            endcase
          end
        end
        ST_SCAN1: begin
          if (rd_live && dom_by) begin
            out_res.verdict <= VERDICT_DOMINATED;
            state   <= ST_DONE;
            rd_live <= 1'b0;
          end else if (rd_idx >= count) begin
            if (!rd_live) begin
              rd_idx  <= '0;
              state   <= ST_SCAN2;
            end
            rd_live <= 1'b0;
          end else begin
            rd_idx  <= rd_idx + 1'b1;
            rd_live <= 1'b1;
          end
        end
        ST_SCAN2: begin
          if (rd_live) begin
            if (dom_over) begin
              removed <= removed + 1'b1;
            end else begin
              wr_idx <= wr_idx + 1'b1;
            end
          end
          if (rd_idx >= count) begin
            if (!rd_live) begin
              out_res.removed_count <= CntW'(removed);
              out_res.verdict <= (removed != '0) ? VERDICT_DOMINATES : VERDICT_NEUTRAL;
              if (cur.kind == KIND_INSERT) begin
                count <= wr_idx;
                state <= ST_APPEND;
              end else begin
                state <= ST_DONE;
              end
            end
            rd_live <= 1'b0;
          end else begin
            rd_idx  <= rd_idx + 1'b1;
            rd_live <= 1'b1;
          end
        end
        ST_APPEND: begin
          if (count < NW'(ARCHIVE_DEPTH)) begin
            count          <= count + 1'b1;
            out_res.stored <= 1'b1;
          end else begin
            out_res.overflow <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          out_res.entry_count <= CntW'(count);
          out_valid <= 1'b1;
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/pareto_archive_dominance.sv @@
// Two-objective Pareto archive that minimizes both objectives.
// Requests enter on the s_axis channel: tuser carries the kind (load,
// classify, insert) and tdata the two signed Q15.16 objectives. Each request
// yields one result on m_axis with the verdict, the removed count, the stored
// and overflow flags and the entry count after the request.
// A two-entry queue takes requests while the archive engine works, so the
// sender is held only when two requests are waiting.
// The engine reads one archive entry per cycle from its memory. A load goes
// straight to the append step; a classify or insert makes up to two passes over
// the archive entries, one pass to find a dominating entry and one pass that counts dominated
// entries and, on insert, compacts the archive in place.
// The result waits in an output register until m_axis_tready; the engine
// holds meanwhile while the queue still fills.
// Tolerances are to be written on the cfg channel only while idle; the block itself
// does not enforce this. Index 0 is the first objective tolerance and index 1 the
// margin. Reset empties the archive and sets the tolerances to 0 and 66.
module pareto_archive_dominance #(
  parameter int unsigned ARCHIVE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // obj_first, obj_second
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // verdict, removed_count, stored, overflow, entry_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pad_pkg::*;

  logic [TolW-1:0] tol_first;
  logic [TolW-1:0] tol_margin;
  cmd_t in_cmd;
  cmd_t q_cmd;
  res_t res;
  logic q_valid;
  logic q_ready;
  logic busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_first  <= '0;
      tol_margin <= TolW'(66);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOL_FIRST:  tol_first  <= cfg_data;
        REG_TOL_MARGIN: tol_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_cmd.kind       = kind_t'(s_axis_tuser);
  assign in_cmd.obj_first  = s_axis_tdata[31:0];
  assign in_cmd.obj_second = s_axis_tdata[63:32];

  pad_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (in_cmd),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  pad_back #(.ARCHIVE_DEPTH(ARCHIVE_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .tol_first  (tol_first),
    .tol_margin (tol_margin),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (res),
    .busy       (busy)
  );

  assign m_axis_tdata = {6'd0, res.entry_count, res.overflow, res.stored,
                         res.removed_count, res.verdict};

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !m_axis_tvalid) else $error("result without work");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(res.stored && res.overflow)) else $error("stored and overflow");
  a_dominated_nothing: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.verdict == VERDICT_DOMINATED) |->
      (!res.stored && res.removed_count == '0)) else $error("dominated changed archive");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import pad_pkg::*;

  localparam int Depth = 64;
  localparam int CycleLimit = 2000000;

  typedef struct {
    kind_t kind;
    logic [31:0] obj_first;
    logic [31:0] obj_second;
  } request_t;

  typedef struct {
    verdict_t verdict;
    logic [6:0] removed_count;
    logic stored;
    logic overflow;
    logic [6:0] entry_count;
  } outcome_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [15:0] cfg_data;

  pareto_archive_dominance dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  request_t pending_q[$];
  outcome_t outcome_q[$];
  logic signed [31:0] arch_first[Depth];
  logic signed [31:0] arch_second[Depth];
  int arch_count;
  logic [15:0] tol_first;
  logic [15:0] tol_margin;
  int mismatches;
  int cycles;
  int burst_left;
  int gap_left;
  int stall_phase;
  bit in_taken;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit beats(logic signed [31:0] a1, logic signed [31:0] a2,
                               logic signed [31:0] b1, logic signed [31:0] b2);
    longint d1;
    longint d2;
    d1 = longint'(a1) - longint'(b1);
    d2 = longint'(a2) - longint'(b2);
    if (d1 > longint'(tol_first)) return 0;
    if (d2 > longint'(tol_margin)) return 0;
    return (-d1 > longint'(tol_margin)) || (-d2 > longint'(tol_margin));
  endfunction

  function automatic outcome_t archive_update(request_t r);
    outcome_t o;
    bit hit;
    int w;
    o.verdict = VERDICT_NEUTRAL;
    o.removed_count = '0;
    o.stored = 1'b0;
    o.overflow = 1'b0;
    if (r.kind == KIND_LOAD) begin
      if (arch_count < Depth) begin
        arch_first[arch_count] = r.obj_first;
        arch_second[arch_count] = r.obj_second;
        arch_count++;
        o.stored = 1'b1;
      end else begin
        o.overflow = 1'b1;
      end
    end else if (r.kind == KIND_CLASSIFY || r.kind == KIND_INSERT) begin
      hit = 0;
      for (int i = 0; i < arch_count; i++)
        if (beats(arch_first[i], arch_second[i], r.obj_first, r.obj_second)) hit = 1;
      if (hit) begin
        o.verdict = VERDICT_DOMINATED;
      end else begin
        w = 0;
        for (int i = 0; i < arch_count; i++) begin
          if (beats(r.obj_first, r.obj_second, arch_first[i], arch_second[i])) begin
            o.removed_count++;
          end else if (r.kind == KIND_INSERT) begin
            arch_first[w] = arch_first[i];
            arch_second[w] = arch_second[i];
            w++;
          end
        end
        if (r.kind == KIND_INSERT) begin
          arch_count = w;
          if (arch_count < Depth) begin
            arch_first[arch_count] = r.obj_first;
            arch_second[arch_count] = r.obj_second;
            arch_count++;
            o.stored = 1'b1;
          end else begin
            o.overflow = 1'b1;
          end
        end
        o.verdict = (o.removed_count != 0) ? VERDICT_DOMINATES : VERDICT_NEUTRAL;
      end
    end
    o.entry_count = 7'(arch_count);
    return o;
  endfunction

  function automatic logic [31:0] near_value(logic [31:0] base);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return base;
      2: return base + 32'($urandom_range(0, 200)) - 32'd100;
      3: return base + 32'($urandom_range(0, 140000)) - 32'd70000;
      4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return base + 32'($urandom_range(0, 4000000)) - 32'd2000000;
    endcase
  endfunction

  task automatic queue_request(kind_t k, logic [31:0] f, logic [31:0] s);
    request_t r;
    r.kind = k;
    r.obj_first = f;
    r.obj_second = s;
    pending_q = {pending_q, r};
  endtask

  task automatic write_tolerance(logic [0:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TOL_FIRST) tol_first = val;
    else tol_margin = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || outcome_q.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_phase(int count, int max_kind);
    logic [31:0] base_f;
    logic [31:0] base_s;
    int k;
    base_f = $urandom;
    base_s = $urandom;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (k < 3 && max_kind == 3) begin
        queue_request(KIND_NONE, $urandom, $urandom);
      end else begin
        if ($urandom_range(0, 30) == 0) begin
          base_f = $urandom;
          base_s = $urandom;
        end
        queue_request(k < 15 ? KIND_LOAD : (k < 50 ? KIND_CLASSIFY : KIND_INSERT),
                      near_value(base_f), near_value(base_s));
      end
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      m_axis_tready <= (stall_phase % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (s_axis_tvalid && !in_taken) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_q[0].kind;
        s_axis_tdata <= {pending_q[0].obj_second, pending_q[0].obj_first};
        pending_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    request_t r;
    outcome_t want;
    outcome_t got;
    if (!rst) begin
      cycles <= cycles + 1;
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        r.kind = kind_t'(s_axis_tuser);
        r.obj_first = s_axis_tdata[31:0];
        r.obj_second = s_axis_tdata[63:32];
        want = archive_update(r);
        outcome_q = {outcome_q, want};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.verdict = verdict_t'(m_axis_tdata[1:0]);
        got.removed_count = m_axis_tdata[8:2];
        got.stored = m_axis_tdata[9];
        got.overflow = m_axis_tdata[10];
        got.entry_count = m_axis_tdata[17:11];
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", m_axis_tdata);
        end else begin
          want = outcome_q.pop_front();
          if (got.verdict !== want.verdict || got.removed_count !== want.removed_count
              || got.stored !== want.stored || got.overflow !== want.overflow
              || got.entry_count !== want.entry_count || m_axis_tdata[23:18] !== '0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("Mismatch: expected v=%0d rm=%0d st=%0b ov=%0b n=%0d, ",
                     want.verdict, want.removed_count, want.stored, want.overflow,
                     want.entry_count);
              $display("got v=%0d rm=%0d st=%0b ov=%0b n=%0d",
                       got.verdict, got.removed_count, got.stored,
                       got.overflow, got.entry_count);
            end
          end
        end
      end
      if (cycles > CycleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    arch_count = 0;
    tol_first = 16'd0;
    tol_margin = 16'd66;
    mismatches = 0;
    cycles = 0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    in_taken = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_request(KIND_CLASSIFY, 32'h0, 32'h0);
    queue_request(KIND_INSERT, 32'h0001_0000, 32'h0001_0000);
    queue_request(KIND_INSERT, 32'h0001_0000, 32'h0001_0000);
    queue_request(KIND_INSERT, 32'h0001_0000 + 32'd66, 32'h0000_0000);
    queue_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
    queue_request(KIND_CLASSIFY, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_request(KIND_CLASSIFY, 32'h8000_0000, 32'h8000_0000);
    queue_request(KIND_LOAD, 32'h7fff_ffff, 32'h8000_0000);
    queue_request(KIND_LOAD, 32'h8000_0000, 32'h7fff_ffff);
    queue_request(KIND_NONE, 32'hffff_ffff, 32'hffff_ffff);
    queue_request(KIND_CLASSIFY, 32'hffff_ffff, 32'hffff_ffff);
    queue_request(KIND_INSERT, 32'h8000_0000, 32'h8000_0000);
    for (int i = 0; i < 66; i++) queue_request(KIND_LOAD, 32'(i * 1000), 32'(-i * 1000));
    queue_request(KIND_INSERT, 32'h7000_0000, 32'h7000_0000);
    queue_request(KIND_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    wait_drained();

    write_tolerance(REG_TOL_FIRST, 16'hffff);
    write_tolerance(REG_TOL_MARGIN, 16'h0000);
    random_phase(500, 3);
    write_tolerance(REG_TOL_FIRST, 16'd0);
    write_tolerance(REG_TOL_MARGIN, 16'hffff);
    random_phase(500, 3);
    write_tolerance(REG_TOL_FIRST, 16'($urandom));
    write_tolerance(REG_TOL_MARGIN, 16'($urandom));
    random_phase(500, 3);
    write_tolerance(REG_TOL_FIRST, 16'd0);
    write_tolerance(REG_TOL_MARGIN, 16'd66);
    random_phase(500, 3);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
